// File: rtl/core/fce_pkg.sv
package fce_pkg;

  // Bus operations on the input channel
  typedef enum logic [2:0] {
    OP_STATUS    = 3'd0,
    OP_DATA_RD   = 3'd1,
    OP_DATA_WR   = 3'd2,
    OP_TERM_CNT  = 3'd3,
    OP_INT_QUERY = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_EXE = 2'd1,
    PH_RES = 2'd2
  } phase_t;

  // Command codes (low five bits of the first command byte)
  localparam logic [4:0] CMD_SPECIFY   = 5'h03;
  localparam logic [4:0] CMD_READ_DATA = 5'h06;
  localparam logic [4:0] CMD_RECAL     = 5'h07;
  localparam logic [4:0] CMD_SENSE_INT = 5'h08;
  localparam logic [4:0] CMD_READ_ID   = 5'h0A;
  localparam logic [4:0] CMD_SEEK      = 5'h0F;

  // Main status bits
  localparam logic [7:0] MS_RQM = 8'h80;
  localparam logic [7:0] MS_DIO = 8'h40;
  localparam logic [7:0] MS_EXM = 8'h20;
  localparam logic [7:0] MS_CB  = 8'h10;
  localparam logic [7:0] MS_DRV = 8'h0F;

  // ST0 bits
  localparam logic [7:0] ST0_SE = 8'h20;
  localparam logic [7:0] ST0_HD = 8'h04;

  localparam int CMD_DEPTH = 9;
  localparam int RES_DEPTH = 7;
  localparam int ADDR_W    = 20;
  localparam int LBA_W     = 16;

  typedef logic [7:0] byte_t;

  function automatic logic [3:0] cmd_length(input logic [4:0] code);
    logic [3:0] len;
    unique case (code) inside
      5'h06, 5'h0C, 5'h05, 5'h09, 5'h02, 5'h11, 5'h19, 5'h1D: len = 4'd9;
      5'h0D:                                                  len = 4'd6;
      5'h03, 5'h0F:                                           len = 4'd3;
      5'h0A, 5'h07, 5'h04:                                    len = 4'd2;
      default:                                                len = 4'd1;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/fce_if.sv
interface fce_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_byte;
  logic [7:0] disk_byte;
  logic       clear_interrupt;

  modport source (output valid, operation, write_byte, disk_byte, clear_interrupt,
                  input ready);
  modport sink   (input valid, operation, write_byte, disk_byte, clear_interrupt,
                  output ready);
endinterface

interface fce_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic        interrupt_answer;
  logic [19:0] disk_address;
  logic        disk_address_valid;

  modport source (output valid, read_value, interrupt_answer, disk_address,
                  disk_address_valid, input ready);
  modport sink   (input valid, read_value, interrupt_answer, disk_address,
                  disk_address_valid, output ready);
endinterface

// File: rtl/core/floppy_controller_command_engine_top.sv
// Single-drive floppy controller command engine (765 style).
// in_ch carries one bus access per item: status read, data register read
// or write, terminal count or interrupt query. out_ch returns exactly one
// item per input item, in order: the byte read, the interrupt answer and
// the disk image byte address for the next execution-phase read.
// Both channels use valid/ready; an item moves when both are high.
// Pipeline: input register -> controller state update -> sector number
// multiply -> byte address multiply and output register.
// Throughput is one item per cycle while out_ch is not stalled; the four
// stages all advance together.
// When out_ch stalls, the whole pipe holds and in_ch.ready drops in the
// same cycle, so nothing is lost or repeated. The host returns the image
// byte for the last address it saw as disk_byte on a later read.
// Reset (rst_n low, synchronous) empties the pipe, puts the controller in
// command phase with RQM set, drive on track 0, no interrupt pending.
module floppy_controller_command_engine_top #(
  parameter int TRACK_COUNT       = 80,
  parameter int SECTORS_PER_TRACK = 9,
  parameter int SECTOR_BYTES      = 512
) (
  input  logic          clk,
  input  logic          rst_n,
  fce_in_if.sink        in_ch,
  fce_out_if.source     out_ch
);

  localparam int POS_W     = $clog2(SECTOR_BYTES);
  localparam int SIZE_CODE = $clog2(SECTOR_BYTES / 128 + 1) - 1;
  localparam int PROD_W    = fce_pkg::LBA_W + POS_W + 1;

  // Stage advance: whole pipe moves unless the output item is stalled
  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 0: input register ----------------
  logic             v0_r;
  fce_pkg::op_t     op0_r;
  fce_pkg::byte_t   wb0_r;
  fce_pkg::byte_t   disk0_r;
  logic             clr0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
    if (adv) begin
      op0_r   <= fce_pkg::op_t'(in_ch.operation);
      wb0_r   <= in_ch.write_byte;
      disk0_r <= in_ch.disk_byte;
      clr0_r  <= in_ch.clear_interrupt;
    end
  end

  // ---------------- controller state ----------------
  fce_pkg::phase_t phase_r, phase_nxt;
  fce_pkg::byte_t  cmd_r [fce_pkg::CMD_DEPTH];
  fce_pkg::byte_t  cmd_nxt [fce_pkg::CMD_DEPTH];
  logic [3:0]      cnt_r, cnt_nxt;
  logic [3:0]      clen_r, clen_nxt;
  fce_pkg::byte_t  res_r [fce_pkg::RES_DEPTH];
  fce_pkg::byte_t  res_nxt [fce_pkg::RES_DEPTH];
  logic [2:0]      ridx_r, ridx_nxt;
  logic [2:0]      rlen_r, rlen_nxt;
  fce_pkg::byte_t  ms_r, ms_nxt;
  fce_pkg::byte_t  st0_r, st0_nxt;       // ST1/ST2 stay zero, ST3 is never read back
  fce_pkg::byte_t  trk_r, trk_nxt;
  fce_pkg::byte_t  sec_r, sec_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic            int_r, int_nxt;

  fce_pkg::byte_t  rv;
  logic            ia;

  // Combinational step scratch
  fce_pkg::byte_t  view [fce_pkg::CMD_DEPTH];
  logic [3:0]      widx;
  logic [3:0]      cnt_inc;
  logic [3:0]      len_eff;
  logic            do_seek;
  fce_pkg::byte_t  seek_trk;
  logic            head;
  logic            valid_now;
  logic [POS_W:0]  pos_inc;
  logic [8:0]      sec_inc;
  logic [2:0]      ridx_inc;

  assign valid_now = (trk_r < 8'(TRACK_COUNT)) && (sec_r != 8'd0) &&
                     (sec_r <= 8'(SECTORS_PER_TRACK));

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    clen_nxt  = clen_r;
    res_nxt   = res_r;
    ridx_nxt  = ridx_r;
    rlen_nxt  = rlen_r;
    ms_nxt    = ms_r;
    st0_nxt   = st0_r;
    trk_nxt   = trk_r;
    sec_nxt   = sec_r;
    pos_nxt   = pos_r;
    int_nxt   = int_r;
    rv        = 8'd0;
    ia        = 1'b0;
    do_seek   = 1'b0;
    seek_trk  = 8'd0;
    pos_inc   = {1'b0, pos_r} + (POS_W+1)'(1);
    sec_inc   = {1'b0, sec_r} + 9'd1;
    ridx_inc  = ridx_r + 3'd1;

    // Command buffer as it looks with the incoming byte written
    widx    = (cnt_r > 4'd8) ? 4'd0 : cnt_r;
    view    = cmd_r;
    view[widx] = wb0_r;
    head    = view[1][2];
    cnt_inc = widx + 4'd1;
    len_eff = (widx == 4'd0) ? fce_pkg::cmd_length(wb0_r[4:0]) : clen_r;

    case (op0_r)
      fce_pkg::OP_STATUS: begin
        ms_nxt = ms_r | fce_pkg::MS_RQM;
        rv     = ms_nxt;
      end
      fce_pkg::OP_DATA_RD: begin
        if (phase_r == fce_pkg::PH_EXE) begin
          rv = valid_now ? disk0_r : 8'd0;
          if (pos_inc >= (POS_W+1)'(SECTOR_BYTES)) begin
            pos_nxt = '0;
            sec_nxt = sec_inc[7:0];
            if (sec_inc > 9'(SECTORS_PER_TRACK)) begin
              phase_nxt = fce_pkg::PH_RES;
              ms_nxt    = ms_r & ~fce_pkg::MS_EXM;
            end
          end else begin
            pos_nxt = pos_inc[POS_W-1:0];
          end
        end else if (phase_r == fce_pkg::PH_RES) begin
          if (ridx_r != 3'd7) begin
            rv = res_r[ridx_r];
          end
          ridx_nxt = ridx_inc;
          if (ridx_inc == rlen_r || rlen_r == 3'd0) begin
            phase_nxt = fce_pkg::PH_CMD;
            ms_nxt    = ms_r & ~(fce_pkg::MS_DIO | fce_pkg::MS_CB);
          end
        end
      end
      fce_pkg::OP_DATA_WR: begin
        if (phase_r == fce_pkg::PH_CMD) begin
          cmd_nxt  = view;
          clen_nxt = len_eff;
          cnt_nxt  = cnt_inc;
          if (cnt_inc >= len_eff) begin
            cnt_nxt = 4'd0;
            case (view[0][4:0])
              fce_pkg::CMD_READ_DATA: begin
                res_nxt[0] = st0_r;
                res_nxt[1] = 8'd0;
                res_nxt[2] = 8'd0;
                res_nxt[3] = trk_r;
                res_nxt[4] = view[3];
                res_nxt[5] = view[4];
                res_nxt[6] = 8'(SIZE_CODE);
                rlen_nxt   = 3'd7;
                ridx_nxt   = 3'd0;
                int_nxt    = 1'b1;
                sec_nxt    = view[4];
                pos_nxt    = '0;
                ms_nxt     = ms_r | fce_pkg::MS_DIO | fce_pkg::MS_EXM;
                phase_nxt  = fce_pkg::PH_EXE;
              end
              fce_pkg::CMD_READ_ID: begin
                res_nxt[0] = st0_r;
                res_nxt[1] = 8'd0;
                res_nxt[2] = 8'd0;
                res_nxt[3] = trk_r;
                res_nxt[4] = {7'd0, head};
                res_nxt[5] = 8'd1;
                res_nxt[6] = 8'(SIZE_CODE);
                rlen_nxt   = 3'd7;
                ridx_nxt   = 3'd0;
                int_nxt    = 1'b1;
                ms_nxt     = ms_r | fce_pkg::MS_DIO;
                phase_nxt  = fce_pkg::PH_RES;
              end
              fce_pkg::CMD_RECAL: begin
                do_seek  = 1'b1;
                seek_trk = 8'd0;
              end
              fce_pkg::CMD_SEEK: begin
                do_seek  = 1'b1;
                seek_trk = view[2];
              end
              fce_pkg::CMD_SENSE_INT: begin
                res_nxt[0] = st0_r;
                res_nxt[1] = trk_r;
                rlen_nxt   = 3'd2;
                ridx_nxt   = 3'd0;
                st0_nxt    = 8'd0;
                ms_nxt     = (ms_r & ~fce_pkg::MS_DRV) | fce_pkg::MS_DIO;
                phase_nxt  = fce_pkg::PH_RES;
              end
              fce_pkg::CMD_SPECIFY: begin
                ms_nxt = ms_r & ~fce_pkg::MS_CB;
              end
              default: ;
            endcase
            if (do_seek) begin
              trk_nxt = seek_trk;
              st0_nxt = (head ? (st0_r | fce_pkg::ST0_HD) : (st0_r & ~fce_pkg::ST0_HD))
                        | fce_pkg::ST0_SE;
              ms_nxt  = ms_r | (8'd1 << view[1][1:0]);
              int_nxt = 1'b1;
            end
          end
        end
      end
      fce_pkg::OP_TERM_CNT: begin
        if (phase_r == fce_pkg::PH_EXE) begin
          phase_nxt = fce_pkg::PH_RES;
          ms_nxt    = ms_r & ~fce_pkg::MS_EXM;
          int_nxt   = 1'b1;
        end
      end
      fce_pkg::OP_INT_QUERY: begin
        if (int_r) begin
          ia = 1'b1;
          if (clr0_r) begin
            int_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  logic step;
  assign step = adv && v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fce_pkg::PH_CMD;
      cnt_r   <= 4'd0;
      clen_r  <= 4'd9;
      ridx_r  <= 3'd0;
      rlen_r  <= 3'd0;
      ms_r    <= fce_pkg::MS_RQM;
      st0_r   <= 8'd0;
      trk_r   <= 8'd0;
      sec_r   <= 8'd0;
      pos_r   <= '0;
      int_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      clen_r  <= clen_nxt;
      ridx_r  <= ridx_nxt;
      rlen_r  <= rlen_nxt;
      ms_r    <= ms_nxt;
      st0_r   <= st0_nxt;
      trk_r   <= trk_nxt;
      sec_r   <= sec_nxt;
      pos_r   <= pos_nxt;
      int_r   <= int_nxt;
    end
    if (step) begin
      cmd_r <= cmd_nxt;
      res_r <= res_nxt;
    end
  end

  // ---------------- stage 1: post-step snapshot ----------------
  logic             v1_r;
  fce_pkg::byte_t   rv1_r;
  logic             ia1_r;
  fce_pkg::byte_t   trk1_r;
  logic             head1_r;
  fce_pkg::byte_t   sec1_r;
  logic [POS_W-1:0] pos1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      rv1_r   <= rv;
      ia1_r   <= ia;
      trk1_r  <= trk_nxt;
      head1_r <= cmd_nxt[1][2];
      sec1_r  <= sec_nxt;
      pos1_r  <= pos_nxt;
    end
  end

  // ---------------- stage 2: sector number ----------------
  logic                     v2_r;
  fce_pkg::byte_t           rv2_r;
  logic                     ia2_r;
  logic [fce_pkg::LBA_W-1:0] lba2_r;
  logic [POS_W-1:0]         pos2_r;
  logic                     av2_r;
  logic [fce_pkg::LBA_W-1:0] lba;
  logic                     av1;

  assign lba = fce_pkg::LBA_W'({trk1_r, head1_r}) * fce_pkg::LBA_W'(SECTORS_PER_TRACK)
               + fce_pkg::LBA_W'(sec1_r) - fce_pkg::LBA_W'(1);
  assign av1 = (trk1_r < 8'(TRACK_COUNT)) && (sec1_r != 8'd0) &&
               (sec1_r <= 8'(SECTORS_PER_TRACK));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      rv2_r  <= rv1_r;
      ia2_r  <= ia1_r;
      lba2_r <= lba;
      pos2_r <= pos1_r;
      av2_r  <= av1;
    end
  end

  // ---------------- stage 3: byte address, output register ----------------
  logic [PROD_W-1:0]          addr_full;
  fce_pkg::byte_t             rv3_r;
  logic                       ia3_r;
  logic [fce_pkg::ADDR_W-1:0] addr3_r;
  logic                       av3_r;

  assign addr_full = PROD_W'(lba2_r) * PROD_W'(SECTOR_BYTES) + PROD_W'(pos2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r;
    end
    if (adv) begin
      rv3_r   <= rv2_r;
      ia3_r   <= ia2_r;
      addr3_r <= av2_r ? addr_full[fce_pkg::ADDR_W-1:0] : '0;
      av3_r   <= av2_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.read_value         = rv3_r;
  assign out_ch.interrupt_answer   = ia3_r;
  assign out_ch.disk_address       = addr3_r;
  assign out_ch.disk_address_valid = av3_r;

`ifndef SYNTH
  // EXM is set exactly while the execution phase runs
  a_exm_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ((ms_r & fce_pkg::MS_EXM) != 8'd0) == (phase_r == fce_pkg::PH_EXE))
    else $error("EXM out of step with phase");

  // DIO is set in execution and result phases only
  a_dio_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ((ms_r & fce_pkg::MS_DIO) != 8'd0) == (phase_r != fce_pkg::PH_CMD))
    else $error("DIO out of step with phase");

  // Result phase never runs past the end of the result bytes
  a_res_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == fce_pkg::PH_RES) |-> (ridx_r < rlen_r))
    else $error("result index past result length");

  // Command byte count stays below the command length
  a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < clen_r)
    else $error("command count reached command length");
`endif

endmodule
